// ----- sv/pef_pkg.sv -----
// pef_pkg: shared types and constants for the power envelope follower
// no dependencies; used by pef_regs, pef_div, power_envelope_follower and the bench
package pef_pkg;

  localparam int unsigned PowerWidth = 16;
  localparam int unsigned FracWidth = 8;
  localparam int unsigned EnvWidth = PowerWidth + FracWidth;
  localparam int unsigned CfgWidth = 16;
  localparam int unsigned AddrWidth = 4;

  // register indexes (byte address = 4 * index)
  localparam logic [1:0] RegRiseDivisor = 2'd0;
  localparam logic [1:0] RegRiseJumpThreshold = 2'd1;
  localparam logic [1:0] RegFallJumpThreshold = 2'd2;
  localparam logic [1:0] RegFallDivisor = 2'd3;

  typedef enum logic [1:0] {
    KIND_GENTLE_RISE = 2'd0,
    KIND_JUMP_UP = 2'd1,
    KIND_GENTLE_FALL = 2'd2,
    KIND_JUMP_DOWN = 2'd3
  } kind_t;

  typedef struct packed {
    logic [CfgWidth-1:0] rise_divisor;
    logic [CfgWidth-1:0] rise_jump_threshold;
    logic [CfgWidth-1:0] fall_jump_threshold;
    logic [CfgWidth-1:0] fall_divisor;
  } cfg_t;

  // a zero divisor acts as one
  function automatic logic [CfgWidth-1:0] nonzero_div(input logic [CfgWidth-1:0] d);
    nonzero_div = (d == '0) ? CfgWidth'(1) : d;
  endfunction

endpackage

// ----- sv/power_envelope_follower.sv -----
// power_envelope_follower: top level, envelope sequencer and output register
// depends on pef_pkg, pef_regs, pef_div
// sequence: a jump request loads the envelope, then the output register; a gentle
//   step runs 24 divider steps, the envelope update, then the output load
// a new request is taken only once the previous result has entered the output register
// reset: envelope and previous sample clear to zero, registers return to defaults
module power_envelope_follower (
  input  logic        clk,
  input  logic        rst,
  // input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [15:0] power_w
  // output stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // [23:0] envelope_level
  output logic [1:0]  m_tuser,   // [1:0] update_kind
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_DONE
  } state_t;

  state_t                         state;
  pef_pkg::cfg_t                  cfg;
  pef_pkg::kind_t                 kind;
  pef_pkg::kind_t                 kind_next;
  logic [pef_pkg::EnvWidth-1:0]   envelope;
  logic [pef_pkg::PowerWidth-1:0] past_power;

  logic                           s_accept;
  logic                           out_free;
  logic                           out_load;
  logic [pef_pkg::PowerWidth-1:0] power_w;
  logic [pef_pkg::EnvWidth-1:0]   target;
  logic                           above;
  logic [pef_pkg::PowerWidth:0]   rise;
  logic [pef_pkg::PowerWidth:0]   fall;
  logic                           rise_jump;
  logic                           fall_jump;
  logic                           jump;

  logic                           div_start;
  logic [pef_pkg::EnvWidth-1:0]   div_dividend;
  logic [pef_pkg::CfgWidth-1:0]   div_divisor;
  logic                           div_done;
  logic [pef_pkg::EnvWidth-1:0]   div_quotient;

  pef_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  pef_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quotient)
  );

  assign s_tready = (state == ST_IDLE);
  assign s_accept = s_tvalid & s_tready;
  // output slot can take a result when empty or being drained
  assign out_free = !m_tvalid || m_tready;
  // finished result moves into the output slot
  assign out_load = (state == ST_DONE) && out_free;

  assign power_w = s_tdata;
  // sample widened to 16.8
  assign target = {power_w, {pef_pkg::FracWidth{1'b0}}};
  assign above = target > envelope;

  // signed 17-bit differences against the previous sample
  assign rise = {1'b0, power_w} - {1'b0, past_power};
  assign fall = {1'b0, past_power} - {1'b0, power_w};
  assign rise_jump = !($signed(rise) < $signed({1'b0, cfg.rise_jump_threshold}));
  assign fall_jump = !($signed(fall) < $signed({1'b0, cfg.fall_jump_threshold}));
  assign jump = above ? rise_jump : fall_jump;

  always_comb begin
    if (above) begin
      kind_next = rise_jump ? pef_pkg::KIND_JUMP_UP : pef_pkg::KIND_GENTLE_RISE;
    end else begin
      kind_next = fall_jump ? pef_pkg::KIND_JUMP_DOWN : pef_pkg::KIND_GENTLE_FALL;
    end
  end

  // gentle step: distance to the sample divided by the selected divisor
  assign div_start = s_accept & !jump;
  assign div_dividend = above ? (target - envelope) : (envelope - target);
  assign div_divisor = above ? pef_pkg::nonzero_div(cfg.rise_divisor)
                             : pef_pkg::nonzero_div(cfg.fall_divisor);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      envelope <= '0;
      past_power <= '0;
      kind <= pef_pkg::KIND_GENTLE_RISE;
      m_tvalid <= 1'b0;
      m_tdata <= '0;
      m_tuser <= '0;
    end else begin
      // output payload, loaded with the finished envelope
      if (out_load) begin
        m_tvalid <= 1'b1;
        m_tdata <= envelope;
        m_tuser <= kind;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (s_accept) begin
            past_power <= power_w;
            kind <= kind_next;
            if (jump) begin
              envelope <= target;
              state <= ST_DONE;
            end else begin
              state <= ST_DIV;
            end
          end
        end
        ST_DIV: begin
          if (div_done) begin
            // a gentle step never passes the sample, so no overflow here
            if (kind == pef_pkg::KIND_GENTLE_RISE) begin
              envelope <= envelope + div_quotient;
            end else begin
              envelope <= envelope - div_quotient;
            end
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_done_in_div: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == ST_DIV)
    else $error("divider finished outside the divide state");
  a_busy_after_req: assert property (@(posedge clk) disable iff (rst)
    s_accept |=> !s_tready)
    else $error("ready again right after a request");
  a_result_loaded: assert property (@(posedge clk) disable iff (rst)
    out_load |=> m_tvalid && state == ST_IDLE)
    else $error("finished result not presented");

endmodule

// ----- sv/pef_regs.sv -----
// pef_regs: apb configuration registers of the power envelope follower
// depends on pef_pkg
module pef_regs (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [pef_pkg::AddrWidth-1:0] paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  output pef_pkg::cfg_t                 cfg
);

  logic       wr_en;
  logic [1:0] reg_idx;

  assign pready = 1'b1;
  assign wr_en = psel & penable & pwrite;
  assign reg_idx = paddr[3:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.rise_divisor <= 16'd2;
      cfg.rise_jump_threshold <= 16'd200;
      cfg.fall_jump_threshold <= 16'd200;
      cfg.fall_divisor <= 16'd2;
    end else if (wr_en) begin
      case (reg_idx)
        pef_pkg::RegRiseDivisor: cfg.rise_divisor <= pwdata[15:0];
        pef_pkg::RegRiseJumpThreshold: cfg.rise_jump_threshold <= pwdata[15:0];
        pef_pkg::RegFallJumpThreshold: cfg.fall_jump_threshold <= pwdata[15:0];
        pef_pkg::RegFallDivisor: cfg.fall_divisor <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      pef_pkg::RegRiseDivisor: prdata = {16'd0, cfg.rise_divisor};
      pef_pkg::RegRiseJumpThreshold: prdata = {16'd0, cfg.rise_jump_threshold};
      pef_pkg::RegFallJumpThreshold: prdata = {16'd0, cfg.fall_jump_threshold};
      pef_pkg::RegFallDivisor: prdata = {16'd0, cfg.fall_divisor};
      default: prdata = 32'd0;
    endcase
  end

endmodule

// ----- sv/pef_div.sv -----
// pef_div: bit-serial restoring divider, one quotient bit per cycle
// depends on pef_pkg
module pef_div (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [pef_pkg::EnvWidth-1:0] dividend,
  input  logic [pef_pkg::CfgWidth-1:0] divisor,
  output logic                         done,
  output logic [pef_pkg::EnvWidth-1:0] quotient
);

  localparam int unsigned CntWidth = $clog2(pef_pkg::EnvWidth);
  localparam logic [CntWidth-1:0] LastStep = CntWidth'(pef_pkg::EnvWidth - 1);

  logic                         busy;
  logic [CntWidth-1:0]          cnt;
  logic [pef_pkg::CfgWidth-1:0] dvs;
  logic [pef_pkg::CfgWidth-1:0] rem;
  logic [pef_pkg::CfgWidth:0]   rem_sh;
  logic [pef_pkg::CfgWidth:0]   rem_sub;
  logic                         ge;

  // shift in next dividend bit, try subtract
  assign rem_sh = {rem, quotient[pef_pkg::EnvWidth-1]};
  assign rem_sub = rem_sh - {1'b0, dvs};
  assign ge = rem_sh >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt <= '0;
      end else if (busy) begin
        cnt <= cnt + CntWidth'(1);
        if (cnt == LastStep) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quotient <= dividend;
      dvs <= divisor;
      rem <= '0;
    end else if (busy) begin
      rem <= ge ? rem_sub[pef_pkg::CfgWidth-1:0] : rem_sh[pef_pkg::CfgWidth-1:0];
      quotient <= {quotient[pef_pkg::EnvWidth-2:0], ge};
    end
  end

  a_start_busy: assert property (@(posedge clk) disable iff (rst) start |=> busy)
    else $error("divider not busy after start");
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("divider done while still busy");
  a_cnt_range: assert property (@(posedge clk) disable iff (rst) busy |-> cnt <= LastStep)
    else $error("divider step count out of range");

endmodule

// ----- tb/tb_power_envelope_follower.sv -----
// tb_power_envelope_follower: self-checking bench for the power envelope follower
// depends on pef_pkg and power_envelope_follower; drives both streams and the apb port,
// predicts each envelope update in a scoreboard class and checks it on the output stream
module tb_power_envelope_follower;

  // cycles with no handshake on either stream before the run is abandoned
  localparam int StallLimit = 2000;
  // extra wait in drain() once every result has come back
  localparam int SettleCycles = 40;

  typedef struct {
    logic [23:0]     level;
    pef_pkg::kind_t  kind;
  } envelope_step_t;

  // keeps a private copy of the registers, the envelope and the previous sample
  class envelope_scoreboard;
    logic [15:0] rise_div;
    logic [15:0] rise_thr;
    logic [15:0] fall_thr;
    logic [15:0] fall_div;
    logic [23:0] envelope;
    logic [15:0] last_power;
    envelope_step_t pending[$];
    int errors;
    int checked;
    int kind_seen[4];

    function new();
      rise_div = 16'd2;
      rise_thr = 16'd200;
      fall_thr = 16'd200;
      fall_div = 16'd2;
      envelope = '0;
      last_power = '0;
      errors = 0;
      checked = 0;
      foreach (kind_seen[i]) kind_seen[i] = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [15:0] v);
      case (idx)
        pef_pkg::RegRiseDivisor:       rise_div = v;
        pef_pkg::RegRiseJumpThreshold: rise_thr = v;
        pef_pkg::RegFallJumpThreshold: fall_thr = v;
        pef_pkg::RegFallDivisor:       fall_div = v;
        default: ;
      endcase
    endfunction

    // works out the envelope update that an accepted power sample causes
    function void note_sample(logic [15:0] p);
      logic [23:0] target;
      logic [23:0] divisor;
      logic signed [17:0] rise;
      logic signed [17:0] fall;
      envelope_step_t step;
      target = {p, 8'h00};
      rise = $signed({2'b00, p}) - $signed({2'b00, last_power});
      fall = $signed({2'b00, last_power}) - $signed({2'b00, p});
      if (target > envelope) begin
        if (rise < $signed({2'b00, rise_thr})) begin
          divisor = (rise_div == '0) ? 24'd1 : {8'h00, rise_div};
          envelope = envelope + (target - envelope) / divisor;
          step.kind = pef_pkg::KIND_GENTLE_RISE;
        end else begin
          envelope = target;
          step.kind = pef_pkg::KIND_JUMP_UP;
        end
      end else begin
        // a sample equal to the envelope counts as a fall
        if (fall < $signed({2'b00, fall_thr})) begin
          divisor = (fall_div == '0) ? 24'd1 : {8'h00, fall_div};
          envelope = envelope - (envelope - target) / divisor;
          step.kind = pef_pkg::KIND_GENTLE_FALL;
        end else begin
          envelope = target;
          step.kind = pef_pkg::KIND_JUMP_DOWN;
        end
      end
      last_power = p;
      step.level = envelope;
      pending.push_back(step);
    endfunction

    function void check_result(logic [23:0] level, logic [1:0] kind);
      envelope_step_t want;
      if (pending.size() == 0) begin
        errors++;
        $display("%0t: result with nothing expected: level %h kind %0d", $time, level, kind);
        return;
      end
      want = pending.pop_front();
      checked++;
      kind_seen[want.kind]++;
      if (level !== want.level) begin
        errors++;
        $display("%0t: envelope_level expected %h actual %h", $time, want.level, level);
      end
      if (kind !== want.kind) begin
        errors++;
        $display("%0t: update_kind expected %0d actual %0d", $time, want.kind, kind);
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata = '0;   // [15:0] power_w
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;        // [23:0] envelope_level
  logic [1:0]  m_tuser;        // [1:0] update_kind
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  envelope_scoreboard sb = new();

  int send_idle_pct = 0;   // chance per cycle that the sender holds back
  int stall_pct = 0;       // chance per cycle that the receiver stalls
  int idle_cycles = 0;
  int n_samples = 0;
  int n_settings = 0;

  power_envelope_follower uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // receiver: check each accepted result, then pick next cycle's ready at random
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_result(m_tdata, m_tuser);
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // watchdog: ends the run when neither stream moves for too long
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= StallLimit) begin
      $display("%0t: no handshake for %0d cycles, %0d results outstanding",
               $time, idle_cycles, sb.pending.size());
      $display("Verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // one power request; valid stays high from one request straight into the next
  // unless the sender decides to idle first
  task automatic send_sample(input logic [15:0] p);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= p;
    do @(posedge clk); while (!s_tready);
    sb.note_sample(p);
    n_samples++;
  endtask

  task automatic play(input logic [15:0] seq[$]);
    foreach (seq[i]) send_sample(seq[i]);
  endtask

  // apb write: setup cycle, access cycle, then one cycle with psel low
  task automatic write_reg(input logic [1:0] idx, input logic [15:0] v);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= {16'($urandom), v};  // upper half must be ignored
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    sb.set_reg(idx, v);
    @(posedge clk);
  endtask

  task automatic set_all(input logic [15:0] rd, input logic [15:0] rt,
                         input logic [15:0] ft, input logic [15:0] fd);
    write_reg(pef_pkg::RegRiseDivisor, rd);
    write_reg(pef_pkg::RegRiseJumpThreshold, rt);
    write_reg(pef_pkg::RegFallJumpThreshold, ft);
    write_reg(pef_pkg::RegFallDivisor, fd);
    n_settings++;
  endtask

  // let every outstanding result come back, then give the divider time to go idle
  task automatic drain();
    s_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  function automatic logic [15:0] rand_reg(input bit is_div);
    case ($urandom_range(3))
      0:       return is_div ? 16'($urandom_range(1)) : 16'd0;
      1:       return 16'hffff;
      2:       return is_div ? 16'($urandom_range(16, 1)) : 16'($urandom_range(1000));
      default: return 16'($urandom_range(65535));
    endcase
  endfunction

  // mostly small moves around the last sample and samples right at the jump
  // thresholds or the envelope, with some full-range noise
  function automatic logic [15:0] pick_power();
    int base;
    int p;
    int span;
    base = int'(sb.last_power);
    span = 1 << $urandom_range(12);
    case ($urandom_range(9))
      0:       p = int'($urandom_range(65535));
      1:       p = $urandom_range(1) ? 65535 : 0;
      2, 3:    p = base + int'(sb.rise_thr) + int'($urandom_range(2)) - 1;
      4:       p = base - int'(sb.fall_thr) + int'($urandom_range(2)) - 1;
      5:       p = int'(sb.envelope >> 8) + int'($urandom_range(2)) - 1;
      default: p = base + int'($urandom_range(2 * span)) - span;
    endcase
    if (p < 0) p = 0;
    if (p > 65535) p = 65535;
    return 16'(p);
  endfunction

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset settings: flat zero, full-scale jump up, equal sample as a fall,
    // jump down, gentle fall, rise exactly at the threshold, gentle falls, jumps down
    play('{16'd0, 16'd65535, 16'd65535, 16'd65000, 16'd64900, 16'd65100,
           16'd65050, 16'd65060, 16'd1000, 16'd0});
    drain();

    // jumps out of reach: a rise below the previous sample and a fall
    // above it both take the gentle step
    set_all(16'd2, 16'hffff, 16'hffff, 16'd2);
    play('{16'd60000, 16'd40000, 16'd10000, 16'd15000});
    drain();

    // zero thresholds: any non-negative move jumps
    set_all(16'd0, 16'd0, 16'd0, 16'd0);
    play('{16'd15000, 16'd15000, 16'd20000, 16'd19000});
    drain();

    // zero divisors behave as one on the gentle falls; the full-scale rise meets the threshold and jumps
    set_all(16'd0, 16'hffff, 16'hffff, 16'd0);
    play('{16'd0, 16'd65535, 16'd1});

    // random part: new settings for every phase and one of four idling patterns in turn
    for (int k = 0; k < 12; k++) begin
      drain();
      case (k)
        0:       set_all(16'hffff, 16'hffff, 16'hffff, 16'hffff);
        1:       set_all(16'd0, 16'd0, 16'd0, 16'd0);
        default: set_all(rand_reg(1'b1), rand_reg(1'b0), rand_reg(1'b0), rand_reg(1'b1));
      endcase
      case (k % 4)
        0:       begin send_idle_pct = 0;  stall_pct = 0;  end
        1:       begin send_idle_pct = 76; stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  stall_pct = 76; end
        default: begin send_idle_pct = 20; stall_pct = 20; end
      endcase
      repeat (95) send_sample(pick_power());
    end
    drain();

    $display("summary: %0d power samples under %0d register settings, %0d results checked",
             n_samples, n_settings, sb.checked);
    $display("summary: gentle rise %0d, jump up %0d, gentle fall %0d, jump down %0d",
             sb.kind_seen[pef_pkg::KIND_GENTLE_RISE], sb.kind_seen[pef_pkg::KIND_JUMP_UP],
             sb.kind_seen[pef_pkg::KIND_GENTLE_FALL], sb.kind_seen[pef_pkg::KIND_JUMP_DOWN]);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ----- power_envelope_follower.f -----
sv/pef_pkg.sv
sv/pef_regs.sv
sv/pef_div.sv
sv/power_envelope_follower.sv
tb/tb_power_envelope_follower.sv
